// ===== rtl/core/packed_pattern_unpacker_macros.svh =====
// Assertion macros shared by the packed pattern unpacker RTL.
// Included by the top level; the assertions drop out when ASSERT_OFF is defined.
`ifndef PACKED_PATTERN_UNPACKER_MACROS_SVH
`define PACKED_PATTERN_UNPACKER_MACROS_SVH
`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define PPU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Antecedent implies the consequent in the same cycle.
`define PPU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define PPU_ASSERT(label, prop, msg)
`define PPU_ASSERT_IMP(label, ante, cons, msg)
`endif
`endif

// ===== rtl/core/ppu_pkg.sv =====
// Types, constants and the note conversion of the packed pattern unpacker.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps
`default_nettype none

package ppu_pkg;

  localparam int unsigned MAX_CHANNELS = 32;
  localparam int unsigned CHAN_W       = 5;
  localparam int unsigned ROWF_W       = 6;
  localparam int unsigned NUM_CH_W     = 6;
  localparam logic [NUM_CH_W-1:0] NUM_CH_RESET = 6'd32;

  localparam logic [7:0] NOTE_KEY_OFF = 8'd254;
  localparam logic [7:0] NOTE_EMPTY   = 8'd255;
  localparam logic [7:0] NOTE_BIAS    = 8'd12;

  // Phase of the byte decoder: which byte of an entry comes next.
  typedef enum logic [2:0] {
    PH_PACK,
    PH_NOTE,
    PH_INSTR,
    PH_VOL,
    PH_EFFECT,
    PH_INFO
  } phase_e;

  // One result, field order as on the output stream.
  typedef struct packed {
    logic [7:0]        fx_info;
    logic [7:0]        effect;
    logic [7:0]        volume;
    logic [7:0]        instrument;
    logic [7:0]        note;
    logic [ROWF_W-1:0] row;
    logic [CHAN_W-1:0] channel;
    logic              is_entry;
    logic              pattern_end;
  } result_t;

  // Octave in the high nibble, semitone in the low one; the two special codes pass.
  function automatic logic [7:0] map_note(input logic [7:0] raw);
    logic [7:0] octave_x12;
    octave_x12 = {1'b0, raw[7:4], 3'b000} + {2'b00, raw[7:4], 2'b00};
    if (raw == NOTE_KEY_OFF || raw == NOTE_EMPTY) begin
      return raw;
    end
    return octave_x12 + {4'h0, raw[3:0]} + NOTE_BIAS;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/packed_pattern_unpacker.sv =====
// Packed pattern unpacker: decodes the packed byte stream of one tracker pattern.
// Depends on ppu_pkg and on packed_pattern_unpacker_macros.svh for its assertions.
`timescale 1ns / 1ps
`default_nettype none
`include "packed_pattern_unpacker_macros.svh"

//  Channel   Direction  Width  Contents
//  s_axis    in         8      one raw pattern byte per request
//  m_axis    out        56     one decoded entry or the pattern end marker
//  apb       in/out     32     register 0 at byte address 0: num_channels
//
// The decoder state and the result are updated at the edge that accepts the byte,
// so a request may follow in each cycle while s_axis_tready_o is high. The rate is
// set by the phase register and its decode logic.
// A result sits in the output register; if it is not taken, the next result goes
// to a skid register and only then does s_axis_tready_o fall, so a stalled output
// stops the input only once two results are waiting.
// Reset clears the phase, the row counter and both valid bits, and sets
// num_channels to 32. There is no clearing pass.
module packed_pattern_unpacker
  import ppu_pkg::*;
#(
  parameter int unsigned ROWS = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input stream; tdata: pattern_byte[7:0].
  input  wire logic [7:0]  s_axis_tdata_i,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // Output stream; tdata from bit 0: channel[4:0], row[10:5], note[18:11],
  // instrument[26:19], volume[34:27], effect[42:35], fx_info[50:43], zeros.
  output logic [55:0]      m_axis_tdata_o,
  // tuser: is_entry.
  output logic             m_axis_tuser_o,
  // tlast: pattern_end.
  output logic             m_axis_tlast_o,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // The row counter holds 0 to ROWS-1; its increment needs one bit more.
  localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [ROW_W:0] ROWS_CNT = (ROW_W + 1)'(ROWS);
  localparam logic [ROWF_W-1:0] END_ROW = ROWF_W'((ROWS - 1) % 64);

  // Configuration register.
  logic [NUM_CH_W-1:0] num_ch_q;
  logic                cfg_wr;

  // Decoder state.
  phase_e          phase_q, phase_d;
  logic [2:0]      pend_q, pend_d;
  logic [CHAN_W-1:0] chan_q, chan_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [7:0]      note_q, note_d;
  logic [7:0]      instr_q, instr_d;
  logic [7:0]      vol_q, vol_d;
  logic [7:0]      fx_q, fx_d;

  // Output register and skid stage.
  result_t out_q, skid_q, res;
  logic    out_valid_q, skid_valid_q;
  logic    res_valid;
  logic    in_acc, out_take, new_res;

  // Decode helpers.
  logic [7:0]         in_byte;
  logic [ROW_W:0]     row_inc;
  logic [ROW_W+5:0]   row_wide;
  logic               do_adv;
  logic [7:0]         info;
  logic               chan_ok;

  // --------------------------------------------------------------------------
  // APB register. Only index 0 exists; byte offsets within the word are ignored.
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {{(32 - NUM_CH_W){1'b0}}, num_ch_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_ch_q <= NUM_CH_RESET;
    end else if (cfg_wr) begin
      num_ch_q <= pwdata[NUM_CH_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Handshakes. A byte is refused only while the skid register is occupied.
  // --------------------------------------------------------------------------
  assign s_axis_tready_o = !skid_valid_q;
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_take = out_valid_q && m_axis_tready_i;
  assign new_res  = in_acc && res_valid;
  assign in_byte  = s_axis_tdata_i;

  assign row_inc  = {1'b0, row_q} + (ROW_W + 1)'(1);
  assign row_wide = (ROW_W + 6)'(row_q);

  // --------------------------------------------------------------------------
  // Byte decoder. A zero pack byte ends the row; any other announces which bytes
  // follow. Each following byte but the effect info fills one held field, and the
  // entry is finished after its last byte.
  always_comb begin
    phase_d   = phase_q;
    pend_d    = pend_q;
    chan_d    = chan_q;
    row_d     = row_q;
    note_d    = note_q;
    instr_d   = instr_q;
    vol_d     = vol_q;
    fx_d      = fx_q;
    do_adv    = 1'b0;
    info      = 8'h00;
    res_valid = 1'b0;
    res       = '0;
    chan_ok   = 1'b0;

    case (phase_q)
      PH_NOTE: begin
        note_d  = map_note(in_byte);
        phase_d = PH_INSTR;
      end
      PH_INSTR: begin
        instr_d = in_byte;
        do_adv  = 1'b1;
      end
      PH_VOL: begin
        vol_d  = in_byte;
        do_adv = 1'b1;
      end
      PH_EFFECT: begin
        fx_d    = in_byte;
        phase_d = PH_INFO;
      end
      PH_INFO: begin
        info   = in_byte;
        do_adv = 1'b1;
      end
      default: begin
        phase_d = PH_PACK;
        if (in_byte == 8'h00) begin
          // End of row; the last row of the pattern also gives the end marker.
          if (row_inc == ROWS_CNT) begin
            row_d           = '0;
            res_valid       = 1'b1;
            res.row         = END_ROW;
            res.pattern_end = 1'b1;
          end else begin
            row_d = row_inc[ROW_W-1:0];
          end
        end else begin
          chan_d  = in_byte[CHAN_W-1:0];
          pend_d  = in_byte[7:5];
          note_d  = 8'h00;
          instr_d = 8'h00;
          vol_d   = 8'h00;
          fx_d    = 8'h00;
          do_adv  = 1'b1;
        end
      end
    endcase

    // Move to the next announced group, or finish the entry when none is left.
    if (do_adv) begin
      if (pend_d[0]) begin
        pend_d[0] = 1'b0;
        phase_d   = PH_NOTE;
      end else if (pend_d[1]) begin
        pend_d[1] = 1'b0;
        phase_d   = PH_VOL;
      end else if (pend_d[2]) begin
        pend_d[2] = 1'b0;
        phase_d   = PH_EFFECT;
      end else begin
        phase_d = PH_PACK;
        chan_ok = ({1'b0, chan_d} < num_ch_q) &&
                  (NUM_CH_W'(chan_d) < NUM_CH_W'(MAX_CHANNELS));
        if (chan_ok) begin
          res_valid        = 1'b1;
          res.channel      = chan_d;
          res.row          = row_wide[ROWF_W-1:0];
          res.note         = note_d;
          res.instrument   = instr_d;
          res.volume       = vol_d;
          res.effect       = fx_d;
          res.fx_info      = info;
          res.is_entry     = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PACK;
      pend_q  <= '0;
      chan_q  <= '0;
      row_q   <= '0;
      note_q  <= '0;
      instr_q <= '0;
      vol_q   <= '0;
      fx_q    <= '0;
    end else if (in_acc) begin
      phase_q <= phase_d;
      pend_q  <= pend_d;
      chan_q  <= chan_d;
      row_q   <= row_d;
      note_q  <= note_d;
      instr_q <= instr_d;
      vol_q   <= vol_d;
      fx_q    <= fx_d;
    end
  end

  // --------------------------------------------------------------------------
  // Output register with skid stage. The skid register only fills while the
  // output register holds a result that is not being taken.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_take) begin
      out_valid_q  <= skid_valid_q || new_res;
      skid_valid_q <= 1'b0;
    end else if (new_res) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_take) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (new_res) begin
        out_q <= res;
      end
    end else if (new_res) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b0_0000, out_q.fx_info, out_q.effect, out_q.volume,
                            out_q.instrument, out_q.note, out_q.row, out_q.channel};
  assign m_axis_tuser_o  = out_q.is_entry;
  assign m_axis_tlast_o  = out_q.pattern_end;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  `PPU_ASSERT(a_skid_behind_out, !skid_valid_q || out_valid_q, "skid full with output empty")
  `PPU_ASSERT_IMP(a_effect_flags_done, phase_q == PH_EFFECT || phase_q == PH_INFO,
                  pend_q == 3'b000, "groups still pending in effect phase")
  `PPU_ASSERT_IMP(a_mid_entry_note_done, phase_q != PH_PACK, !pend_q[0],
                  "note group still pending inside an entry")
  `PPU_ASSERT_IMP(a_marker_kind, m_axis_tvalid_o, m_axis_tuser_o != m_axis_tlast_o,
                  "result is neither entry nor end marker")

endmodule

`default_nettype wire

// ===== tb/packed_pattern_unpacker_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for packed_pattern_unpacker: sends packed pattern bytes,
// predicts every decoded entry and pattern end marker, and checks the output stream.
// Depends on ppu_pkg and the packed_pattern_unpacker RTL.

module packed_pattern_unpacker_tb;
  import ppu_pkg::*;

  localparam int unsigned TB_ROWS         = 64;
  localparam logic [5:0]  ROW_LAST        = 6'(TB_ROWS - 1);
  localparam logic [2:0]  ADDR_NUM_CH     = 3'd0;
  // Results are registered at the edge that accepts a byte, so this slack covers
  // anything still in the output register or the skid register.
  localparam int unsigned DRAIN_SLACK     = 4;
  localparam int unsigned MAX_REPORTS     = 10;
  localparam int unsigned HOLD_OFF_CYCLES = 300;

  logic        clk      = 1'b0;
  logic        rst_n    = 1'b0;
  logic [7:0]  s_tdata  = '0;
  logic        s_tvalid = 1'b0;
  wire         s_tready;
  // tdata from bit 0: channel, row, note, instrument, volume, effect, fx_info.
  wire  [55:0] m_tdata;
  wire         m_tuser;   // is_entry
  wire         m_tlast;   // pattern_end
  wire         m_tvalid;
  logic        m_tready = 1'b0;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  wire  [31:0] prdata;
  wire         pready;

  // Predictor state: the decoder as the block should hold it, plus its register.
  logic [5:0]  num_ch_cfg = NUM_CH_RESET;
  phase_e      dec_phase  = PH_PACK;
  logic [2:0]  pend_flags = '0;
  logic [4:0]  cur_chan   = '0;
  logic [6:0]  row_cnt    = '0;
  logic [7:0]  held_note  = '0;
  logic [7:0]  held_instr = '0;
  logic [7:0]  held_vol   = '0;
  logic [7:0]  held_fx    = '0;

  // Decoded entries and end markers still awaited on the output stream, oldest first.
  result_t     unpacked_q[$];

  int unsigned snd_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;
  int          hold_left    = 0;
  int unsigned bytes_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned markers_seen = 0;
  int unsigned mismatches   = 0;

  packed_pattern_unpacker #(
    .ROWS(TB_ROWS)
  ) dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Octave in the high nibble, semitone in the low one, one octave of bias on top.
  // Key off and the empty note pass through untouched.
  function automatic logic [7:0] note_to_midi(input logic [7:0] raw);
    int unsigned midi;
    midi = 12 * raw[7:4] + raw[3:0] + 12;
    if (raw == NOTE_KEY_OFF || raw == NOTE_EMPTY) begin
      return raw;
    end
    return midi[7:0];
  endfunction

  // An entry is complete once no announced byte is left; it is reported only when
  // its channel lies below the active limit, which saturates at MAX_CHANNELS.
  task automatic close_entry(input logic [7:0] info);
    int unsigned limit;
    result_t     r;
    limit = (num_ch_cfg > MAX_CHANNELS) ? MAX_CHANNELS : num_ch_cfg;
    dec_phase = PH_PACK;
    if (cur_chan < limit) begin
      r              = '0;
      r.channel      = cur_chan;
      r.row          = row_cnt[5:0];
      r.note         = held_note;
      r.instrument   = held_instr;
      r.volume       = held_vol;
      r.effect       = held_fx;
      r.fx_info      = info;
      r.is_entry     = 1'b1;
      unpacked_q.insert(unpacked_q.size(), r);
    end
  endtask

  // Announced byte groups are taken in order: note and instrument, volume, effect.
  task automatic next_group(input logic [7:0] info);
    if (pend_flags[0]) begin
      pend_flags[0] = 1'b0;
      dec_phase = PH_NOTE;
    end else if (pend_flags[1]) begin
      pend_flags[1] = 1'b0;
      dec_phase = PH_VOL;
    end else if (pend_flags[2]) begin
      pend_flags[2] = 1'b0;
      dec_phase = PH_EFFECT;
    end else begin
      close_entry(info);
    end
  endtask

  // Advances the predicted decoder by one accepted byte.
  task automatic unpack_byte(input logic [7:0] b);
    result_t r;
    case (dec_phase)
      PH_NOTE: begin
        held_note = note_to_midi(b);
        dec_phase = PH_INSTR;
      end
      PH_INSTR: begin
        held_instr = b;
        next_group(8'h00);
      end
      PH_VOL: begin
        held_vol = b;
        next_group(8'h00);
      end
      PH_EFFECT: begin
        held_fx   = b;
        dec_phase = PH_INFO;
      end
      PH_INFO: begin
        next_group(b);
      end
      default: begin
        dec_phase = PH_PACK;
        if (b == 8'h00) begin
          // A zero byte closes the row; closing the last row gives the end marker.
          row_cnt = row_cnt + 7'd1;
          if (row_cnt >= TB_ROWS) begin
            row_cnt       = '0;
            r             = '0;
            r.row         = ROW_LAST;
            r.pattern_end = 1'b1;
            unpacked_q.insert(unpacked_q.size(), r);
          end
        end else begin
          cur_chan   = b[4:0];
          pend_flags = b[7:5];
          held_note  = '0;
          held_instr = '0;
          held_vol   = '0;
          held_fx    = '0;
          next_group(8'h00);
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
    end
  endtask

  // Offers one byte, sometimes after a random gap, and waits for the request
  // to be taken. Only an accepted byte reaches the predictor.
  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < snd_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'($urandom);
      do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    unpack_byte(b);
    bytes_sent++;
  endtask

  // Stops offering and waits until every predicted result has been taken.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (unpacked_q.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  // Writes num_channels over the configuration port, then reads it back.
  // The register holds six bits, so the upper bits of the write are dropped.
  task automatic write_num_channels(input logic [31:0] value);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_NUM_CH;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    num_ch_cfg = value[5:0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field("num_channels readback", value[5:0], prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [7:0] pick_note();
    logic [3:0] octave;
    logic [3:0] semitone;
    octave   = 4'($urandom_range(9));
    semitone = 4'($urandom_range(11));
    case ($urandom_range(9))
      0:       return NOTE_KEY_OFF;
      1:       return NOTE_EMPTY;
      2, 3:    return 8'($urandom);
      default: return {octave, semitone};
    endcase
  endfunction

  // One row of a pattern: zero, one, two or four entries with random channels and
  // flags, sometimes a burst of raw noise, then a zero byte that normally closes the row.
  // Empty rows are common so that the pattern end comes round often.
  task automatic send_row();
    int unsigned n_entries;
    logic [7:0]  pack;
    case ($urandom_range(9))
      0, 1, 2, 3: n_entries = 0;
      4, 5, 6, 7: n_entries = 1;
      8:          n_entries = 2;
      default:    n_entries = 4;
    endcase
    repeat (n_entries) begin
      pack = 8'($urandom);
      if (pack == 8'h00) begin
        pack = 8'($urandom_range(1, 31));
      end
      send_byte(pack);
      if (pack[5]) begin
        send_byte(pick_note());
        send_byte(8'($urandom));
      end
      if (pack[6]) begin
        send_byte(8'($urandom));
      end
      if (pack[7]) begin
        send_byte(8'($urandom));
        send_byte(8'($urandom));
      end
    end
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
    end
    send_byte(8'h00);
  endtask

  task automatic run_random_rows(input int unsigned budget);
    int unsigned stop_at;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) send_row();
  endtask

  // Output side: random back-pressure, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Every accepted result is matched against the oldest prediction, field by field.
  always @(posedge clk) begin : check_output
    result_t want;
    if (rst_n && m_tvalid && m_tready) begin
      if (unpacked_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: result with no prediction waiting, tdata %h", $time, m_tdata);
        end
      end else begin
        want = unpacked_q.pop_front();
        check_field("channel",      want.channel,      m_tdata[4:0]);
        check_field("row",          want.row,          m_tdata[10:5]);
        check_field("note",         want.note,         m_tdata[18:11]);
        check_field("instrument",   want.instrument,   m_tdata[26:19]);
        check_field("volume",       want.volume,       m_tdata[34:27]);
        check_field("effect",       want.effect,       m_tdata[42:35]);
        check_field("fx_info",      want.fx_info,      m_tdata[50:43]);
        check_field("is_entry",     want.is_entry,     m_tuser);
        check_field("pattern_end",  want.pattern_end,  m_tlast);
      end
      results_seen++;
      if (m_tlast) begin
        markers_seen++;
      end
    end
  end

  // The reset value is written back with junk in the unused upper bits.
  task automatic test_register_access();
    write_num_channels(32'hFFFF_FFE0);
  endtask

  // Hand-picked entries: a bare pack byte, every flag on the highest channel with
  // extreme data bytes, key off, the empty note, the highest convertible note, a
  // volume-only and an effect-only entry, and a row end.
  task automatic test_directed_entries();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    send_byte(8'h05);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hAA);
    send_byte(8'h23);
    send_byte(NOTE_KEY_OFF);
    send_byte(8'h01);
    send_byte(8'h24);
    send_byte(NOTE_EMPTY);
    send_byte(8'h07);
    send_byte(8'h30);
    send_byte(8'hFD);
    send_byte(8'h80);
    send_byte(8'h41);
    send_byte(8'h40);
    send_byte(8'h82);
    send_byte(8'h13);
    send_byte(8'h7F);
    send_byte(8'h00);
    drain();
  endtask

  // A limit of zero drops everything, one keeps only channel 0, and anything above
  // 32 keeps every channel. Dropped entries must still swallow their data bytes.
  task automatic test_channel_limits();
    logic [5:0] mid_limit;
    snd_idle_pct = 25;
    rcv_idle_pct = 25;
    write_num_channels(32'd0);
    run_random_rows(100);
    write_num_channels(32'd1);
    run_random_rows(100);
    write_num_channels(32'd63);
    run_random_rows(100);
    mid_limit = 6'($urandom_range(2, 31));
    write_num_channels(($urandom & 32'hFFFF_FFC0) | mid_limit);
    run_random_rows(100);
  endtask

  // With tready held low the output register and the skid register fill after two
  // results; from then on the input must stall while the sender keeps requesting.
  task automatic test_output_backpressure();
    write_num_channels(32'd32);
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_left    = HOLD_OFF_CYCLES;
    repeat (60) send_byte(8'($urandom_range(1, 31)));
    send_byte(8'h00);
    drain();
  endtask

  // Long runs of random rows under three idling regimes: a slow receiver, a
  // slow sender, and both running flat out.
  task automatic test_random_patterns();
    snd_idle_pct = 14;
    rcv_idle_pct = 72;
    write_num_channels(32'hFFFF_FFE0);
    run_random_rows(480);
    write_num_channels($urandom_range(1, 32));
    snd_idle_pct = 72;
    rcv_idle_pct = 14;
    run_random_rows(480);
    write_num_channels(32'd31);
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    run_random_rows(480);
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_access();
    test_directed_entries();
    test_channel_limits();
    test_output_backpressure();
    test_random_patterns();
    $display("Decoded %0d pattern bytes into %0d checked results, %0d of them pattern ends,",
             bytes_sent, results_seen, markers_seen);
    $display("across channel limits from 0 to 63 and a %0d-cycle output hold-off.",
             HOLD_OFF_CYCLES);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: the slowest legal run needs well under a tenth of this.
  initial begin
    #(2_000_000);
    $display("Run timed out with %0d results still awaited.", unpacked_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
